// ===== hdl/qpg_pkg.sv =====
// ----------------------------------------------------------------------------
// qpg_pkg
// Types, codes and small helpers shared by the quadrature pulse generator.
// ----------------------------------------------------------------------------
package qpg_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  localparam logic CH_X = 1'b0;
  localparam logic CH_Y = 1'b1;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_BWD = 1'b1;

  typedef struct packed {
    logic              op;
    logic              channel;
    logic signed [7:0] counts;
  } in_t;

  typedef struct packed {
    logic       x_a;
    logic       x_b;
    logic       y_a;
    logic       y_b;
    logic [7:0] x_pending;
    logic [7:0] y_pending;
  } out_t;

  typedef struct packed {
    logic       tick;
    logic       add;
    logic       clear_on_reverse;
    logic [7:0] counts;
  } chan_cmd_t;

  function automatic logic phase_pin_a(input logic [1:0] ph);
    phase_pin_a = (ph == 2'd1) || (ph == 2'd2);
  endfunction

  function automatic logic phase_pin_b(input logic [1:0] ph);
    phase_pin_b = ph[1];
  endfunction

endpackage

// ===== hdl/qpg_channel.sv =====
// ----------------------------------------------------------------------------
// qpg_channel
// One axis: pending step count, direction and Gray-code phase, with the
// next-state logic for tick and add beats.
// ----------------------------------------------------------------------------
module qpg_channel #(
  parameter int PENDING_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 update,
  input  qpg_pkg::chan_cmd_t   cmd,
  output logic                 pin_a,
  output logic                 pin_b,
  output logic [7:0]           pending_rep
);

  localparam logic [PENDING_BITS-1:0] REP_MAX = PENDING_BITS'(255);

  logic [PENDING_BITS-1:0] pending, pending_next;
  logic                    dir, dir_next;
  logic [1:0]              phase, phase_next;

  logic                    neg;
  logic [8:0]              mag;
  logic                    do_add;
  logic                    reverse;
  logic [PENDING_BITS-1:0] base;
  logic [PENDING_BITS:0]   sum;

  always_comb begin
    neg     = cmd.counts[7];
    mag     = neg ? (9'd256 - {1'b0, cmd.counts}) : {1'b0, cmd.counts};
    do_add  = cmd.add && (cmd.counts != 8'd0);
    reverse = do_add && (neg != dir);
    base    = (reverse && cmd.clear_on_reverse) ? '0 : pending;
    sum     = (PENDING_BITS+1)'(base) + (PENDING_BITS+1)'(mag);

    pending_next = pending;
    dir_next     = dir;
    phase_next   = phase;
    if (do_add) begin
      dir_next     = neg ? qpg_pkg::DIR_BWD : qpg_pkg::DIR_FWD;
      pending_next = sum[PENDING_BITS] ? '1 : sum[PENDING_BITS-1:0];
    end else if (cmd.tick && (pending != '0)) begin
      pending_next = pending - PENDING_BITS'(1);
      phase_next   = (dir == qpg_pkg::DIR_FWD) ? phase + 2'd1 : phase - 2'd1;
    end

    pin_a       = qpg_pkg::phase_pin_a(phase_next);
    pin_b       = qpg_pkg::phase_pin_b(phase_next);
    pending_rep = (pending_next > REP_MAX) ? 8'hFF : pending_next[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      dir     <= qpg_pkg::DIR_FWD;
      phase   <= 2'd0;
    end else if (update) begin
      pending <= pending_next;
      dir     <= dir_next;
      phase   <= phase_next;
    end
  end

endmodule

// ===== hdl/quadrature_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// quadrature_pulse_generator
// Two-axis quadrature pin generator driven by tick and signed add beats.
// ----------------------------------------------------------------------------
// One beat is accepted every cycle unless the output side stalls, and each
// beat yields exactly one result: the beat lands in an input register, both
// axis updates happen in one pass of the per-channel logic, and the pin
// levels and pending counts are captured in the result register. While a
// result waits, one more beat is held in the input register; in_ready falls
// only when both registers are full and out_ready is low. reset_on_reverse is
// written through cfg_we/cfg_data.
module quadrature_pulse_generator #(
  parameter int PENDING_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  qpg_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output qpg_pkg::out_t out_data
);

  logic               reset_on_reverse;
  logic               s1_valid;
  qpg_pkg::in_t       s1_data;
  logic               s1_go;
  logic               update;
  qpg_pkg::chan_cmd_t cmd_x, cmd_y;
  qpg_pkg::out_t      result;
  logic               x_a, x_b, y_a, y_b;
  logic [7:0]         x_pending, y_pending;

  assign s1_go    = !out_valid || out_ready;
  assign update   = s1_valid && s1_go;
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_on_reverse <= 1'b0;
    end else if (cfg_we) begin
      reset_on_reverse <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  always_comb begin
    cmd_x.tick             = (s1_data.op == qpg_pkg::OP_TICK);
    cmd_x.add              = (s1_data.op == qpg_pkg::OP_ADD) &&
                             (s1_data.channel == qpg_pkg::CH_X);
    cmd_x.clear_on_reverse = reset_on_reverse;
    cmd_x.counts           = s1_data.counts;
    cmd_y.tick             = (s1_data.op == qpg_pkg::OP_TICK);
    cmd_y.add              = (s1_data.op == qpg_pkg::OP_ADD) &&
                             (s1_data.channel == qpg_pkg::CH_Y);
    cmd_y.clear_on_reverse = reset_on_reverse;
    cmd_y.counts           = s1_data.counts;
  end

  qpg_channel #(.PENDING_BITS(PENDING_BITS)) u_chan_x (
    .clk         (clk),
    .rst         (rst),
    .update      (update),
    .cmd         (cmd_x),
    .pin_a       (x_a),
    .pin_b       (x_b),
    .pending_rep (x_pending)
  );

  qpg_channel #(.PENDING_BITS(PENDING_BITS)) u_chan_y (
    .clk         (clk),
    .rst         (rst),
    .update      (update),
    .cmd         (cmd_y),
    .pin_a       (y_a),
    .pin_b       (y_b),
    .pending_rep (y_pending)
  );

  always_comb begin
    result.x_a       = x_a;
    result.x_b       = x_b;
    result.y_a       = y_a;
    result.y_b       = y_b;
    result.x_pending = x_pending;
    result.y_pending = y_pending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      out_data <= result;
    end
  end

endmodule

// ===== hdl/qpg_checker.sv =====
// ----------------------------------------------------------------------------
// qpg_checker
// Port-level checks for the quadrature pulse generator, bound to the top.
// ----------------------------------------------------------------------------
module qpg_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input qpg_pkg::out_t out_data
);

  logic [1:0] last_x_pins, last_y_pins;
  logic [7:0] last_x_pend, last_y_pend;
  logic       out_fire;

  assign out_fire = out_valid && out_ready;

  // last delivered beat, starting from the reset levels
  always_ff @(posedge clk) begin
    if (rst) begin
      last_x_pins <= 2'b00;
      last_y_pins <= 2'b00;
      last_x_pend <= 8'd0;
      last_y_pend <= 8'd0;
    end else if (out_fire) begin
      last_x_pins <= {out_data.x_a, out_data.x_b};
      last_y_pins <= {out_data.y_a, out_data.y_b};
      last_x_pend <= out_data.x_pending;
      last_y_pend <= out_data.y_pending;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_gray_step: assert property (@(posedge clk) disable iff (rst)
    out_fire |-> ($countones(last_x_pins ^ {out_data.x_a, out_data.x_b}) <= 1) &&
                 ($countones(last_y_pins ^ {out_data.y_a, out_data.y_b}) <= 1))
    else $error("pins moved more than one phase");

  a_step_uses_count: assert property (@(posedge clk) disable iff (rst)
    out_fire && (last_x_pins != {out_data.x_a, out_data.x_b}) |->
      (out_data.x_pending == last_x_pend - 8'd1) ||
      ((out_data.x_pending == 8'hFF) && (last_x_pend == 8'hFF)))
    else $error("x step without pending decrement");

endmodule

bind quadrature_pulse_generator qpg_checker u_qpg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/tb_quadrature_pulse_generator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadrature_pulse_generator
// Drives tick and add beats into the two-axis quadrature generator and checks
// every result beat field by field against an in-bench model of the pending
// counts, directions and Gray phases. Covers zero, extreme and saturating
// adds, reversal with and without clearing, idle ticks, random traffic with
// gaps on both sides, and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_quadrature_pulse_generator;

  localparam int PEND_W      = 8;
  localparam int WATCHDOG    = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_BEATS = 165;
  localparam logic [PEND_W-1:0] PEND_MAX = '1;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          cfg_we    = 1'b0;
  logic          cfg_data  = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  qpg_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  qpg_pkg::out_t out_data;

  // model state
  logic [PEND_W-1:0] axis_pending [2] = '{default: '0};
  logic              axis_dir     [2] = '{default: qpg_pkg::DIR_FWD};
  logic [1:0]        axis_phase   [2] = '{default: 2'd0};
  logic              clear_on_rev     = 1'b0;

  qpg_pkg::out_t pin_states_q [$];
  int   errors      = 0;
  int   idle_cycles = 0;
  bit   src_gaps    = 1'b1;
  bit   sink_gaps   = 1'b1;
  bit   hold_sink   = 1'b0;

  quadrature_pulse_generator #(
    .PENDING_BITS(PEND_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  task automatic advance_axes(input qpg_pkg::in_t beat, output qpg_pkg::out_t res);
    logic [PEND_W:0] total;
    logic [8:0]      mag;
    logic            newdir;
    int              ch;
    if (beat.op == qpg_pkg::OP_TICK) begin
      for (int c = 0; c < 2; c++) begin
        if (axis_pending[c] != '0) begin
          axis_pending[c] = axis_pending[c] - 1'b1;
          if (axis_dir[c] == qpg_pkg::DIR_FWD) axis_phase[c] = axis_phase[c] + 2'd1;
          else axis_phase[c] = axis_phase[c] - 2'd1;
        end
      end
    end else if (beat.counts != 8'sd0) begin
      ch     = (beat.channel == qpg_pkg::CH_Y) ? 1 : 0;
      newdir = beat.counts[7] ? qpg_pkg::DIR_BWD : qpg_pkg::DIR_FWD;
      mag    = beat.counts[7] ? 9'd256 - {1'b0, beat.counts} : {1'b0, beat.counts};
      if (newdir != axis_dir[ch]) begin
        axis_dir[ch] = newdir;
        if (clear_on_rev) axis_pending[ch] = '0;
      end
      total = {1'b0, axis_pending[ch]} + (PEND_W + 1)'(mag);
      axis_pending[ch] = (total > {1'b0, PEND_MAX}) ? PEND_MAX : total[PEND_W-1:0];
    end
    res.x_a       = axis_phase[0][1] ^ axis_phase[0][0];
    res.x_b       = axis_phase[0][1];
    res.y_a       = axis_phase[1][1] ^ axis_phase[1][0];
    res.y_b       = axis_phase[1][1];
    res.x_pending = (axis_pending[0] > PEND_W'(255)) ? 8'hFF : axis_pending[0][7:0];
    res.y_pending = (axis_pending[1] > PEND_W'(255)) ? 8'hFF : axis_pending[1][7:0];
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // prediction on input beats, checking on output beats
  always @(posedge clk) begin : monitor
    qpg_pkg::out_t want;
    qpg_pkg::out_t pred;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pin_states_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = pin_states_q.pop_front();
          compare_field("x_a", want.x_a, out_data.x_a);
          compare_field("x_b", want.x_b, out_data.x_b);
          compare_field("y_a", want.y_a, out_data.y_a);
          compare_field("y_b", want.y_b, out_data.y_b);
          compare_field("x_pending", want.x_pending, out_data.x_pending);
          compare_field("y_pending", want.y_pending, out_data.y_pending);
        end
      end
      if (in_valid && in_ready) begin
        advance_axes(in_data, pred);
        pin_states_q.push_back(pred);
      end
      if (cfg_we) clear_on_rev = cfg_data;
    end
  end

  always @(posedge clk) begin
    if (!rst && ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result receiver
  initial begin : receiver
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_sink) begin
        gap = LONG_HOLD;
        hold_sink = 1'b0;
      end else begin
        gap = sink_gaps ? $urandom_range(0, 10) : 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_beat(input qpg_pkg::in_t beat);
    int gap;
    gap = src_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pin_states_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reverse_clear(input logic value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic qpg_pkg::in_t mk_beat(input logic op, input logic ch,
                                           input logic signed [7:0] n);
    qpg_pkg::in_t b;
    b.op      = op;
    b.channel = ch;
    b.counts  = n;
    return b;
  endfunction

  function automatic qpg_pkg::in_t random_beat(input bit short_moves);
    qpg_pkg::in_t b;
    int  pick;
    b.channel = 1'($urandom);
    b.counts  = 8'($urandom);
    pick      = $urandom_range(0, 9);
    if (short_moves) b.op = (pick < 7) ? qpg_pkg::OP_TICK : qpg_pkg::OP_ADD;
    else b.op = (pick < 4) ? qpg_pkg::OP_TICK : qpg_pkg::OP_ADD;
    if (b.op == qpg_pkg::OP_ADD) begin
      if (pick == 9 || $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 4))
          0:       b.counts = 8'sd0;
          1:       b.counts = 8'sd127;
          2:       b.counts = -8'sd128;
          3:       b.counts = -8'sd1;
          default: b.counts = 8'sd1;
        endcase
      end else if (short_moves) begin
        b.counts = 8'($urandom_range(0, 15) - 8);
      end
    end
    return b;
  endfunction

  task automatic test_directed_moves;
    set_reverse_clear(1'b0);
    send_beat(mk_beat(qpg_pkg::OP_TICK, qpg_pkg::CH_X, 8'sd0));
    send_beat(mk_beat(qpg_pkg::OP_ADD, qpg_pkg::CH_X, 8'sd0));
    send_beat(mk_beat(qpg_pkg::OP_ADD, qpg_pkg::CH_X, 8'sd127));
    send_beat(mk_beat(qpg_pkg::OP_ADD, qpg_pkg::CH_Y, -8'sd128));
    send_beat(mk_beat(qpg_pkg::OP_TICK, qpg_pkg::CH_X, 8'sd0));
    send_beat(mk_beat(qpg_pkg::OP_TICK, qpg_pkg::CH_Y, 8'sd5));
    send_beat(mk_beat(qpg_pkg::OP_ADD, qpg_pkg::CH_X, -8'sd1));
    send_beat(mk_beat(qpg_pkg::OP_TICK, qpg_pkg::CH_X, 8'sd0));
    send_beat(mk_beat(qpg_pkg::OP_ADD, qpg_pkg::CH_Y, -8'sd128));
    send_beat(mk_beat(qpg_pkg::OP_ADD, qpg_pkg::CH_Y, 8'sd127));
    send_beat(mk_beat(qpg_pkg::OP_TICK, qpg_pkg::CH_Y, -8'sd1));
  endtask

  task automatic test_reverse_clearing;
    set_reverse_clear(1'b1);
    send_beat(mk_beat(qpg_pkg::OP_ADD, qpg_pkg::CH_X, 8'sd5));
    send_beat(mk_beat(qpg_pkg::OP_ADD, qpg_pkg::CH_X, 8'sd3));
    send_beat(mk_beat(qpg_pkg::OP_ADD, qpg_pkg::CH_X, -8'sd2));
    send_beat(mk_beat(qpg_pkg::OP_TICK, qpg_pkg::CH_X, 8'sd0));
    send_beat(mk_beat(qpg_pkg::OP_TICK, qpg_pkg::CH_X, 8'sd0));
    send_beat(mk_beat(qpg_pkg::OP_TICK, qpg_pkg::CH_Y, 8'sd0));
    send_beat(mk_beat(qpg_pkg::OP_ADD, qpg_pkg::CH_Y, -8'sd128));
    send_beat(mk_beat(qpg_pkg::OP_ADD, qpg_pkg::CH_Y, -8'sd128));
    send_beat(mk_beat(qpg_pkg::OP_ADD, qpg_pkg::CH_Y, 8'sd0));
    send_beat(mk_beat(qpg_pkg::OP_ADD, qpg_pkg::CH_Y, 8'sd1));
  endtask

  task automatic test_random_traffic;
    logic setting;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0, 3:    setting = 1'b0;
        1, 2:    setting = 1'b1;
        default: setting = 1'($urandom);
      endcase
      set_reverse_clear(setting);
      src_gaps  = (p != 2);
      sink_gaps = (p != 2) && (p != 4);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        send_beat(random_beat(p % 2 == 1));
      end
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_output_stall;
    set_reverse_clear(1'b0);
    src_gaps  = 1'b0;
    hold_sink = 1'b1;
    for (int i = 0; i < 50; i++) begin
      send_beat(random_beat(1'b0));
    end
    src_gaps = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_moves();
    test_reverse_clearing();
    test_random_traffic();
    test_output_stall();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/qpg_pkg.sv
hdl/qpg_channel.sv
hdl/quadrature_pulse_generator.sv
hdl/qpg_checker.sv
tb/tb_quadrature_pulse_generator.sv
